// ===== rtl/core/tcw_pkg.sv =====
// ============================================================================
// tcw_pkg
// Shared types and constants for the text console writer: field widths,
// operation codes, character codes and the sequencer state encoding.
// ============================================================================
package tcw_pkg;

    // Field widths of one input beat and one result beat.
    localparam int OP_W     = 3;
    localparam int CH_W     = 8;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 32;

    // Operation codes carried in the op field.
    localparam logic [OP_W-1:0] OP_PRINT = 3'd0;
    localparam logic [OP_W-1:0] OP_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [OP_W-1:0] OP_SETCUR = 3'd3;
    localparam logic [OP_W-1:0] OP_PUT   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ  = 3'd5;

    // Character codes with a special meaning.
    localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CH_W-1:0] CH_BLANK   = 8'd32;

    // Register select (paddr[2]) and attribute reset value on the configuration port.
    localparam logic ADDR_ATTRIBUTE = 1'b0;
    localparam logic [7:0] ATTR_RESET = 8'd15;

    // Sequencer states.
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_RDWAIT = 8'b0000_0100,
        S_SCROLL = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_FILL   = 8'b0010_0000,
        S_HOME   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// ============================================================================
// text_console_writer
// Text console engine: a ROWS x COLUMNS cell store with print, backspace,
// clear, cursor placement, direct put and cell read operations.
// ============================================================================
// Usage:
// Commands arrive as beats on the slave stream (s_t*); each beat yields one
// result beat on the master stream (m_t*) carrying the cell read, the linear
// cursor index and the cursor row after the command. The attribute register
// on the APB port colors every cell that is written, blanks included, but not the cells a scroll moves up.
// The block works on one command at a time. s_tready is high only while the
// sequencer is idle. A command is accepted in S_IDLE, executed in S_EXEC and
// its result placed in the output register from S_DONE; an in-range read
// passes S_RDWAIT for the registered memory read, and set cursor or a line
// advance without scroll passes S_HOME to recompute the cursor index.
// A scroll copies rows 1..ROWS-1 up through the single read and write port,
// one cell a cycle, then blanks the bottom row. A clear writes every cell once.
// The output register holds a finished result while m_tready is low, and a
// new command is still accepted; a second finished result then waits in the
// sequencer until the output register frees up.
// Reset clears the cursor, the row and the sequencer and sets the attribute
// to 15; the cell store is not cleared and holds unknown data until written.
// ============================================================================
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Command stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: op[2:0], ch[10:3], row[15:11], col[22:16], zero[23]
    input  logic [tcw_pkg::IN_W-1:0]    s_tdata,
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: cell_data[15:0], cursor_index[26:16], cursor_row[31:27]
    output logic [tcw_pkg::OUT_W-1:0]   m_tdata,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = (AW > CURSOR_W) ? AW : CURSOR_W;

    localparam logic [AW-1:0]    COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0]    LAST_A    = AW'(CELLS - 1);
    localparam logic [AW-1:0]    LROW_A    = AW'((ROWS - 1) * COLUMNS);
    localparam logic [PW-1:0]    COLS_P    = PW'(COLUMNS);
    localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_MAX   = COL_W'(COLUMNS - 1);

    // Cell store.
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    // Control state.
    t_state             r_state, n_state;
    logic [PW-1:0]      r_cursor, n_cursor;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_cp_valid, n_cp_valid;
    logic [AW-1:0]      r_cp_dst, n_cp_dst;
    logic [7:0]         r_attr;

    // Latched command.
    logic [OP_W-1:0]    r_op;
    logic [CH_W-1:0]    r_ch;
    logic [ROW_W-1:0]   r_in_row;
    logic [COL_W-1:0]   r_in_col;
    logic               r_in_range;
    logic [CELL_W-1:0]  r_cell, n_cell;

    // Output register.
    logic                 r_m_valid;
    logic [CELL_W-1:0]    r_m_cell;
    logic [CURSOR_W-1:0]  r_m_cursor;
    logic [ROW_W-1:0]     r_m_row;
    logic                 out_load;

    // Input field views.
    logic [OP_W-1:0]  in_op;
    logic [CH_W-1:0]  in_ch;
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    logic             s_accept;

    assign in_op  = s_tdata[2:0];
    assign in_ch  = s_tdata[10:3];
    assign in_row = s_tdata[15:11];
    assign in_col = s_tdata[22:16];

    assign s_tready = (r_state == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Configuration port: one register, written in the access phase.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_ATTRIBUTE) ? {24'd0, r_attr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_ATTRIBUTE) begin
            r_attr <= pwdata[7:0];
        end
    end

    // Memory: one write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Sequencer next-state and memory control.
    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_col      = r_col;
        n_row      = r_row;
        n_addr     = r_addr;
        n_cp_valid = 1'b0;
        n_cp_dst   = r_cp_dst;
        n_cell     = r_cell;
        out_load   = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = r_addr;

        // A copied cell is written back in the cycle after its read.
        mem_we    = r_cp_valid;
        mem_waddr = r_cp_dst;
        mem_wdata = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_addr  = AW'(AW'(in_row) * COLS_A + AW'(in_col));
                    n_cell  = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    OP_PRINT: begin
                        if (r_ch != CH_NEWLINE) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_cursor[AW-1:0];
                            mem_wdata = {r_attr, r_ch};
                        end
                        if (r_ch == CH_NEWLINE || r_col == COL_MAX) begin
                            // Advance to the next line, scrolling at the bottom.
                            n_col = '0;
                            if (r_row == ROW_MAX) begin
                                n_addr  = COLS_A;
                                n_state = S_SCROLL;
                            end else begin
                                n_row   = r_row + 1'b1;
                                n_state = S_HOME;
                            end
                        end else begin
                            n_cursor = r_cursor + 1'b1;
                            n_col    = r_col + 1'b1;
                        end
                    end
                    OP_BACK: begin
                        if (r_cursor != '0) begin
                            n_cursor  = r_cursor - 1'b1;
                            n_col     = (r_col == '0) ? COL_MAX : r_col - 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = n_cursor[AW-1:0];
                            mem_wdata = {r_attr, CH_BLANK};
                        end
                    end
                    OP_CLEAR: begin
                        n_addr  = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_state = S_FILL;
                    end
                    OP_SETCUR: begin
                        n_row   = (r_in_row > ROW_MAX) ? ROW_MAX : r_in_row;
                        n_col   = (r_in_col > COL_MAX) ? COL_MAX : r_in_col;
                        n_state = S_HOME;
                    end
                    OP_PUT: begin
                        if (r_in_range) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_addr;
                            mem_wdata = {r_attr, r_ch};
                        end
                    end
                    OP_READ: begin
                        if (r_in_range) begin
                            mem_re  = 1'b1;
                            n_state = S_RDWAIT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RDWAIT: begin
                n_cell  = r_rdata;
                n_state = S_DONE;
            end
            S_SCROLL: begin
                // Read one cell a cycle; it lands one row higher next cycle.
                mem_re     = 1'b1;
                n_cp_valid = 1'b1;
                n_cp_dst   = r_addr - COLS_A;
                if (r_addr == LAST_A) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                n_addr  = LROW_A;
                n_state = S_FILL;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = {r_attr, CH_BLANK};
                if (r_addr == LAST_A) begin
                    n_state = S_HOME;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_HOME: begin
                n_cursor = PW'(PW'(r_row) * COLS_P + PW'(r_col));
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cursor   <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_col      <= n_col;
            r_row      <= n_row;
            r_cp_valid <= n_cp_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_cp_dst <= n_cp_dst;
        r_cell   <= n_cell;
        if (s_accept) begin
            r_op       <= in_op;
            r_ch       <= in_ch;
            r_in_row   <= in_row;
            r_in_col   <= in_col;
            r_in_range <= (in_row <= ROW_MAX) && (in_col <= COL_MAX);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_cell   <= r_cell;
            r_m_cursor <= r_cursor[CURSOR_W-1:0];
            r_m_row    <= r_row;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {r_m_row, r_m_cursor, r_m_cell};

endmodule

// ===== rtl/core/tcw_checker.sv =====
// ============================================================================
// tcw_checker
// Port-level checks for the text console writer: reset, stall behavior,
// one command at a time, row range and configuration handshake.
// ============================================================================
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);
    localparam logic [4:0] ROW_MAX = 5'(ROWS - 1);

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result stays offered.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Commands are taken one at a time: a beat is never accepted back to back.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while the previous one is in work");

    // The reported cursor row is always on the screen.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[31:27] <= ROW_MAX)
        else $error("cursor row beyond the last screen row");

    // Configuration writes never wait.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ===== bench/text_console_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. Command beats go in on the
// slave stream and every command is mirrored in a shadow copy of the screen,
// cursor and row. Each result beat is compared field by field with the oldest
// prediction. A directed sequence covers field extremes, wrap, scroll,
// clamping and out-of-range access. Random phases follow, each under its own
// attribute value written over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELL_COUNT     = ROWS * COLUMNS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 150;
    localparam int PHASE_COUNT    = 5;

    // Unused op codes and the attribute register address.
    localparam logic [OP_W-1:0] OP_SPARE6     = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7     = 3'd7;
    localparam logic [2:0]      REG_ATTRIBUTE = 3'd0;

    // Command beat, laid out as on s_tdata.
    typedef struct packed {
        logic             pad;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [CH_W-1:0]  ch;
        logic [OP_W-1:0]  op;
    } t_command;

    // Result beat, laid out as on m_tdata.
    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   cell_data;
    } t_reply;

    // Shadow of the console: screen store, cursor, row and the replies owed.
    class t_screen_shadow;
        logic [CELL_W-1:0] cells [CELL_COUNT];
        bit                filled [CELL_COUNT];
        int                cursor_pos;
        int                line_row;
        logic [7:0]        attribute;
        t_reply            pending_replies [$];
        int                mismatches;

        function new();
            cursor_pos = 0;
            line_row   = 0;
            attribute  = ATTR_RESET;
            mismatches = 0;
        endfunction

        function void put_cell(int idx, logic [CH_W-1:0] code);
            if (idx < CELL_COUNT) begin
                cells[idx]  = {attribute, code};
                filled[idx] = 1'b1;
            end
        endfunction

        // Move to the next row, scrolling the screen up at the bottom.
        function void next_line();
            int i;
            line_row++;
            if (line_row >= ROWS) begin
                for (i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                    cells[i]  = cells[i + COLUMNS];
                    filled[i] = filled[i + COLUMNS];
                end
                for (i = 0; i < COLUMNS; i++)
                    put_cell((ROWS - 1) * COLUMNS + i, CH_BLANK);
                line_row = ROWS - 1;
            end
            cursor_pos = line_row * COLUMNS;
        endfunction

        // True when this command would make the block scroll.
        function bit scrolls_next(t_command c);
            return c.op == OP_PRINT && line_row == ROWS - 1 &&
                   (c.ch == CH_NEWLINE || (cursor_pos + 1) % COLUMNS == 0);
        endfunction

        // Apply one accepted command and queue the reply it owes.
        function void log_command(t_command c);
            t_reply r;
            int     rr;
            int     cc;
            int     i;
            r = '0;
            case (c.op)
                OP_PRINT: begin
                    if (c.ch == CH_NEWLINE) begin
                        next_line();
                    end else begin
                        put_cell(cursor_pos, c.ch);
                        cursor_pos++;
                        if (cursor_pos % COLUMNS == 0)
                            next_line();
                    end
                end
                OP_BACK: begin
                    if (cursor_pos > 0) begin
                        cursor_pos--;
                        put_cell(cursor_pos, CH_BLANK);
                    end
                end
                OP_CLEAR: begin
                    for (i = 0; i < CELL_COUNT; i++)
                        put_cell(i, CH_BLANK);
                    cursor_pos = 0;
                    line_row   = 0;
                end
                OP_SETCUR: begin
                    rr = (c.row >= ROWS) ? ROWS - 1 : c.row;
                    cc = (c.col >= COLUMNS) ? COLUMNS - 1 : c.col;
                    line_row   = rr;
                    cursor_pos = rr * COLUMNS + cc;
                end
                OP_PUT: begin
                    if (c.row < ROWS && c.col < COLUMNS)
                        put_cell(c.row * COLUMNS + c.col, c.ch);
                end
                OP_READ: begin
                    if (c.row < ROWS && c.col < COLUMNS && filled[c.row * COLUMNS + c.col])
                        r.cell_data = cells[c.row * COLUMNS + c.col];
                end
                default: ;
            endcase
            r.cursor = CURSOR_W'(cursor_pos);
            r.row    = ROW_W'(line_row);
            pending_replies.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s: expected %h, got %h", what, want, got);
        endfunction

        // Compare one result beat with the oldest prediction.
        function void compare_reply(logic [OUT_W-1:0] beat);
            t_reply got;
            t_reply want;
            got = beat;
            if (pending_replies.size() == 0) begin
                flag("result beat with nothing owed", '0, beat);
                return;
            end
            want = pending_replies.pop_front();
            if (got.cell_data !== want.cell_data)
                flag("cell_data", 32'(want.cell_data), 32'(got.cell_data));
            if (got.cursor !== want.cursor)
                flag("cursor_index", 32'(want.cursor), 32'(got.cursor));
            if (got.row !== want.row)
                flag("cursor_row", 32'(want.row), 32'(got.row));
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    t_screen_shadow shadow = new();
    bit             calm;
    int             heavy_left;
    int             quiet_cycles = 0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Result side: random back-pressure except during the calm phase.
    always @(negedge i_clk) begin
        m_tready = calm || ($urandom_range(99) >= 16);
    end

    // Check every accepted result beat.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            shadow.compare_reply(m_tdata);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic t_command pack_cmd(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                          logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        t_command c;
        c.pad = 1'b0;
        c.op  = op;
        c.ch  = ch;
        c.row = row;
        c.col = col;
        return c;
    endfunction

    // Send one command beat; called and returns at a falling edge.
    task automatic send_cmd(input t_command c);
        while (!calm && $urandom_range(99) < 16) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        shadow.log_command(c);
        @(negedge i_clk);
    endtask

    // APB write of the attribute register; called at a falling edge.
    task automatic write_attribute(input logic [7:0] value);
        logic [31:0] word;
        word       = $urandom;
        word[7:0]  = value;
        psel       = 1'b1;
        penable    = 1'b0;
        pwrite     = 1'b1;
        paddr      = REG_ATTRIBUTE;
        pwdata     = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        shadow.attribute = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Random commands: prints most often, with scrolls and clears rationed.
    task automatic run_random(input int count);
        t_command c;
        int       n;
        int       pick;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            c = pack_cmd(OP_PRINT, CH_W'($urandom_range(255)),
                         ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
            if (pick < 45) begin
                if ($urandom_range(11) == 0)
                    c.ch = CH_NEWLINE;
            end else if (pick < 55) begin
                c.op = OP_BACK;
            end else if (pick < 57) begin
                c.op = OP_CLEAR;
            end else if (pick < 97) begin
                c.op = (pick < 67) ? OP_SETCUR : (pick < 79) ? OP_PUT : OP_READ;
                if ($urandom_range(3) != 0) begin
                    c.row = ROW_W'($urandom_range(ROWS - 1));
                    c.col = COL_W'($urandom_range(COLUMNS - 1));
                end
                // Never read a cell that was not written yet.
                if (c.op == OP_READ && c.row < ROWS && c.col < COLUMNS &&
                    !shadow.filled[c.row * COLUMNS + c.col])
                    c.row = 5'd31;
            end else begin
                c.op = pick[0] ? OP_SPARE6 : OP_SPARE7;
            end
            // Clears and scrolls walk the whole store, so keep them few.
            if (c.op == OP_CLEAR || shadow.scrolls_next(c)) begin
                if (heavy_left == 0) begin
                    c.op  = OP_SETCUR;
                    c.row = '0;
                end else begin
                    heavy_left--;
                end
            end
            send_cmd(c);
        end
    endtask

    // Stimulus.
    initial begin
        int p;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_rst_n      = 1'b0;
        calm         = 1'b0;
        heavy_left   = 100;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, at the reset attribute. Clear first so every cell is known.
        send_cmd(pack_cmd(OP_CLEAR, 8'h00, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_PRINT, 8'h41, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_PRINT, 8'd8, 5'd31, 7'd127));
        send_cmd(pack_cmd(OP_PRINT, 8'hFF, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_PRINT, 8'h00, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_BACK, 8'hFF, 5'd31, 7'd127));
        send_cmd(pack_cmd(OP_READ, 8'h00, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_READ, 8'h00, 5'd0, 7'd3));
        // Put and read out of range, then at the last cell.
        send_cmd(pack_cmd(OP_PUT, 8'h55, 5'd31, 7'd127));
        send_cmd(pack_cmd(OP_PUT, 8'h55, 5'd25, 7'd0));
        send_cmd(pack_cmd(OP_PUT, 8'hAA, 5'd24, 7'd79));
        send_cmd(pack_cmd(OP_READ, 8'h00, 5'd24, 7'd79));
        send_cmd(pack_cmd(OP_READ, 8'h00, 5'd25, 7'd0));
        send_cmd(pack_cmd(OP_READ, 8'h00, 5'd0, 7'd80));
        // Clamped cursor, then a wrap off the last cell scrolls the screen.
        send_cmd(pack_cmd(OP_SETCUR, 8'h00, 5'd31, 7'd127));
        send_cmd(pack_cmd(OP_PRINT, 8'h5A, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_READ, 8'h00, 5'd23, 7'd79));
        send_cmd(pack_cmd(OP_PRINT, CH_NEWLINE, 5'd0, 7'd0));
        // Backspace at home does nothing; unused codes do nothing.
        send_cmd(pack_cmd(OP_SETCUR, 8'h00, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_BACK, 8'h00, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_SPARE6, 8'hFF, 5'd31, 7'd127));
        send_cmd(pack_cmd(OP_SPARE7, 8'hFF, 5'd31, 7'd127));
        // Backspace across a row boundary leaves the row behind, so the wrap skips one.
        send_cmd(pack_cmd(OP_SETCUR, 8'h00, 5'd3, 7'd0));
        send_cmd(pack_cmd(OP_BACK, 8'h00, 5'd0, 7'd0));
        send_cmd(pack_cmd(OP_PRINT, 8'h78, 5'd0, 7'd0));

        // Random phases, each with its own attribute; one runs without idling.
        for (p = 0; p < PHASE_COUNT; p++) begin
            s_tvalid = 1'b0;
            while (shadow.outstanding() != 0) @(negedge i_clk);
            repeat (8) @(negedge i_clk);
            write_attribute(p == 0 ? 8'h00 : p == 1 ? 8'hFF : 8'($urandom_range(255)));
            calm = (p == 2);
            run_random(PHASE_ITEMS);
        end
        calm     = 1'b0;
        s_tvalid = 1'b0;

        // Drain, then give stray beats a chance to show up.
        while (shadow.outstanding() != 0) @(negedge i_clk);
        repeat (32) @(negedge i_clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
